// ===== rtl/mit_pkg.sv =====
// ----------------------------------------------------------------------------
// mit_pkg
// Shared types and constants of the mip indirection table: item kinds,
// controller states and the command/status bundles between the controller
// and the datapath.
// ----------------------------------------------------------------------------
package mit_pkg;

  localparam int KIND_W     = 3;
  localparam int POS_W      = 9;
  localparam int LVL_W      = 4;
  localparam int SLOT_IO_W  = 16;
  localparam int MAX_LEVELS = 16;

  // tile dirty marks are kept in words of this many bits
  localparam int TROW_BITS  = 32;
  localparam int TBIT_W     = $clog2(TROW_BITS);

  localparam logic [KIND_W-1:0] KIND_READ  = 3'd0;
  localparam logic [KIND_W-1:0] KIND_WRITE = 3'd1;
  localparam logic [KIND_W-1:0] KIND_INVAL = 3'd2;
  localparam logic [KIND_W-1:0] KIND_QUERY = 3'd3;
  localparam logic [KIND_W-1:0] KIND_CLEAR = 3'd4;

  typedef int lvl_arr_t [MAX_LEVELS];

  typedef enum logic [2:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_ADDR,
    ST_TILE,
    ST_READ,
    ST_EXEC
  } state_t;

  typedef struct packed {
    logic sweep;
    logic load;
    logic rd_slot;
    logic rd_tile;
    logic exec;
  } dp_cmd_t;

  typedef struct packed {
    logic sweep_last;
  } dp_status_t;

endpackage

// ===== rtl/mip_indirection_table.sv =====
// ----------------------------------------------------------------------------
// mip_indirection_table
// Mip-chained page indirection table with per-tile and whole-table dirty
// tracking.
// ----------------------------------------------------------------------------
// Usage:
//   A transaction (kind, column, row, level, slot_in) is taken at a rising
//   edge with start high and busy low. Kinds: read, write, invalidate if
//   matching, query tile dirty, clear dirty; other codes read.
//   Its result (in_range, slot_out, changed, tile_dirty, table_dirty) is
//   shown for one cycle with done high; busy drops in that same cycle.
//   The result passes through the address multiply, the tile-index
//   multiply and the registered reads of the slot memory and then the
//   tile-mark memory.
//   The receiver cannot stall; done is a single-cycle strobe.
//   After reset the block sweeps the slot memory to the invalid code, one
//   entry a cycle, with busy high; tile marks read clear and the table-dirty
//   flag reads set.
// ----------------------------------------------------------------------------
module mip_indirection_table import mit_pkg::*; #(
  parameter int SIDE      = 256,
  parameter int SLOT_BITS = 16,
  parameter int TILE_SIDE = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [KIND_W-1:0]    kind,
  input  logic [POS_W-1:0]     column,
  input  logic [POS_W-1:0]     row,
  input  logic [LVL_W-1:0]     level,
  input  logic [SLOT_IO_W-1:0] slot_in,
  output logic                 busy,
  output logic                 done,
  output logic                 in_range,
  output logic [SLOT_IO_W-1:0] slot_out,
  output logic                 changed,
  output logic                 tile_dirty,
  output logic                 table_dirty
);

  dp_cmd_t    cmd;
  dp_status_t status;

  mit_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .busy   (busy),
    .cmd    (cmd)
  );

  mit_dp #(
    .SIDE      (SIDE),
    .SLOT_BITS (SLOT_BITS),
    .TILE_SIDE (TILE_SIDE)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .kind        (kind),
    .column      (column),
    .row         (row),
    .level       (level),
    .slot_in     (slot_in),
    .done        (done),
    .in_range    (in_range),
    .slot_out    (slot_out),
    .changed     (changed),
    .tile_dirty  (tile_dirty),
    .table_dirty (table_dirty)
  );

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("busy not raised after accepted transaction");

  a_latency: assert property (@(posedge clk) disable iff (rst)
    start && !busy |-> ##5 done)
    else $error("result not delivered five cycles after acceptance");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while busy");

  a_out_of_range: assert property (@(posedge clk) disable iff (rst)
    done && !in_range |-> !changed && !tile_dirty)
    else $error("out-of-range transaction changed state");

  a_change_marks: assert property (@(posedge clk) disable iff (rst)
    done && changed |-> tile_dirty && table_dirty)
    else $error("change without dirty marks");

endmodule

// ===== rtl/mit_ram.sv =====
// ----------------------------------------------------------------------------
// mit_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data.
// ----------------------------------------------------------------------------
module mit_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic                                       re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/mit_ctrl.sv =====
// ----------------------------------------------------------------------------
// mit_ctrl
// Sequencer of the indirection table: clearing sweep after reset, then one
// transaction at a time through address, tile, read and execute steps.
// ----------------------------------------------------------------------------
module mit_ctrl import mit_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  dp_status_t status,
  output logic       busy,
  output dp_cmd_t    cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_SWEEP;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_SWEEP: begin
        if (status.sweep_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (start) state_next = ST_ADDR;
      end
      ST_ADDR: state_next = ST_TILE;
      ST_TILE: state_next = ST_READ;
      ST_READ: state_next = ST_EXEC;
      ST_EXEC: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    case (state)
      ST_SWEEP: cmd.sweep = 1'b1;
      ST_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      ST_ADDR: ;
      ST_TILE: cmd.rd_slot = 1'b1;
      ST_READ: cmd.rd_tile = 1'b1;
      ST_EXEC: cmd.exec = 1'b1;
      default: ;
    endcase
  end

endmodule

// ===== rtl/mit_dp.sv =====
// ----------------------------------------------------------------------------
// mit_dp
// Datapath of the indirection table: level geometry, entry and tile address
// arithmetic, slot and tile-mark memories, update logic and result registers.
// ----------------------------------------------------------------------------
module mit_dp import mit_pkg::*; #(
  parameter int SIDE      = 256,
  parameter int SLOT_BITS = 16,
  parameter int TILE_SIDE = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  dp_cmd_t              cmd,
  output dp_status_t           status,
  input  logic [KIND_W-1:0]    kind,
  input  logic [POS_W-1:0]     column,
  input  logic [POS_W-1:0]     row,
  input  logic [LVL_W-1:0]     level,
  input  logic [SLOT_IO_W-1:0] slot_in,
  output logic                 done,
  output logic                 in_range,
  output logic [SLOT_IO_W-1:0] slot_out,
  output logic                 changed,
  output logic                 tile_dirty,
  output logic                 table_dirty
);

  localparam int LvlCount = ($clog2(SIDE + 1) > MAX_LEVELS) ? MAX_LEVELS : $clog2(SIDE + 1);

  function automatic lvl_arr_t build_side();
    lvl_arr_t a;
    int s;
    s = SIDE;
    for (int m = 0; m < MAX_LEVELS; m++) begin
      a[m] = (m < LvlCount) ? s : 0;
      s = s >> 1;
    end
    return a;
  endfunction

  function automatic lvl_arr_t build_across(lvl_arr_t sv);
    lvl_arr_t a;
    for (int m = 0; m < MAX_LEVELS; m++) begin
      a[m] = (sv[m] + TILE_SIDE - 1) / TILE_SIDE;
    end
    return a;
  endfunction

  function automatic lvl_arr_t prefix_sq(lvl_arr_t v);
    lvl_arr_t a;
    int acc;
    acc = 0;
    for (int m = 0; m < MAX_LEVELS; m++) begin
      a[m] = acc;
      acc = acc + v[m] * v[m];
    end
    return a;
  endfunction

  function automatic int sum_sq(lvl_arr_t v);
    int acc;
    acc = 0;
    for (int m = 0; m < MAX_LEVELS; m++) begin
      acc = acc + v[m] * v[m];
    end
    return acc;
  endfunction

  localparam lvl_arr_t LvlSide   = build_side();
  localparam lvl_arr_t LvlAcross = build_across(LvlSide);
  localparam lvl_arr_t LvlBase   = prefix_sq(LvlSide);
  localparam lvl_arr_t LvlTbase  = prefix_sq(LvlAcross);
  localparam int TableDepth      = sum_sq(LvlSide);
  localparam int TileCount       = sum_sq(LvlAcross);
  localparam int TileRows        = (TileCount + TROW_BITS - 1) / TROW_BITS;

  localparam int EA_W    = (TableDepth > 1) ? $clog2(TableDepth) : 1;
  localparam int TROW_AW = (TileRows > 1) ? $clog2(TileRows) : 1;
  localparam int TI_W    = TROW_AW + TBIT_W;
  localparam int SIDE_W  = $clog2(SIDE + 1);
  localparam int CMP_W   = (SIDE_W > POS_W) ? SIDE_W : POS_W;
  localparam int PROD_W  = POS_W + SIDE_W;

  // x / TILE_SIDE as (x * Recip) >> TSh, exact for x below 2**POS_W
  localparam int TSh   = POS_W + $clog2(TILE_SIDE);
  localparam int Recip = ((1 << TSh) + TILE_SIDE - 1) / TILE_SIDE;
  localparam int QP_W  = TSh + POS_W;

  localparam logic [SLOT_BITS-1:0] SlotInv = '1;
  localparam logic [31:0]          InvExt  = 32'(SlotInv);

  // captured transaction
  logic [KIND_W-1:0]    kind_q;
  logic [POS_W-1:0]     col_q;
  logic [POS_W-1:0]     row_q;
  logic [LVL_W-1:0]     lvl_q;
  logic [SLOT_BITS-1:0] slot_q;
  logic [31:0]          slot_ext;

  assign slot_ext = 32'(slot_in);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_q <= kind;
      col_q  <= column;
      row_q  <= row;
      lvl_q  <= level;
      slot_q <= slot_ext[SLOT_BITS-1:0];
    end
  end

  // address step
  logic [SIDE_W-1:0] side_sel;
  logic [PROD_W-1:0] eprod;
  logic [QP_W-1:0]   rq_prod;
  logic [QP_W-1:0]   cq_prod;
  logic [EA_W-1:0]   e_c;
  logic              range_c;

  assign side_sel = SIDE_W'(LvlSide[lvl_q]);
  assign range_c  = (CMP_W'(col_q) < CMP_W'(side_sel)) && (CMP_W'(row_q) < CMP_W'(side_sel));
  assign eprod    = PROD_W'(row_q) * PROD_W'(side_sel);
  assign e_c      = EA_W'(LvlBase[lvl_q]) + EA_W'(eprod) + EA_W'(col_q);
  assign rq_prod  = QP_W'(row_q) * QP_W'(Recip);
  assign cq_prod  = QP_W'(col_q) * QP_W'(Recip);

  logic [EA_W-1:0]  e_q;
  logic [POS_W-1:0] trow_q;
  logic [POS_W-1:0] tcol_q;
  logic             inr_q;

  always_ff @(posedge clk) begin
    e_q    <= e_c;
    inr_q  <= range_c;
    trow_q <= rq_prod[TSh +: POS_W];
    tcol_q <= cq_prod[TSh +: POS_W];
  end

  // tile step
  logic [PROD_W-1:0] tprod;
  logic [TI_W-1:0]   t_q;

  assign tprod = PROD_W'(trow_q) * PROD_W'(LvlAcross[lvl_q]);

  always_ff @(posedge clk) begin
    t_q <= TI_W'(LvlTbase[lvl_q]) + TI_W'(tprod) + TI_W'(tcol_q);
  end

  logic [TROW_AW-1:0] trow_idx;
  logic [TBIT_W-1:0]  tbit_idx;

  assign trow_idx = t_q[TI_W-1:TBIT_W];
  assign tbit_idx = t_q[TBIT_W-1:0];

  // clearing sweep
  logic [EA_W-1:0] sweep_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      sweep_addr <= '0;
    end else if (cmd.sweep) begin
      sweep_addr <= sweep_addr + EA_W'(1);
    end
  end

  assign status.sweep_last = (sweep_addr == EA_W'(TableDepth - 1));

  // memories
  logic [SLOT_BITS-1:0] srdata;
  logic [SLOT_BITS-1:0] nv;
  logic [SLOT_BITS-1:0] swdata;
  logic [EA_W-1:0]      swaddr;
  logic                 swe;
  logic [TROW_BITS-1:0] trdata;
  logic [TROW_BITS-1:0] row_word;
  logic [TROW_BITS-1:0] twdata;
  logic                 chg;
  logic [TileRows-1:0]  row_valid;

  assign swaddr = cmd.sweep ? sweep_addr : e_q;
  assign swdata = cmd.sweep ? SlotInv : nv;
  assign swe    = cmd.sweep || (cmd.exec && chg);

  mit_ram #(
    .WIDTH (SLOT_BITS),
    .DEPTH (TableDepth)
  ) u_slot_ram (
    .clk   (clk),
    .we    (swe),
    .waddr (swaddr),
    .wdata (swdata),
    .re    (cmd.rd_slot),
    .raddr (e_q),
    .rdata (srdata)
  );

  assign row_word = row_valid[trow_idx] ? trdata : '0;
  assign twdata   = row_word | (TROW_BITS'(1) << tbit_idx);

  mit_ram #(
    .WIDTH (TROW_BITS),
    .DEPTH (TileRows)
  ) u_tile_ram (
    .clk   (clk),
    .we    (cmd.exec && chg),
    .waddr (trow_idx),
    .wdata (twdata),
    .re    (cmd.rd_tile),
    .raddr (trow_idx),
    .rdata (trdata)
  );

  // update
  logic        is_wr;
  logic        is_inv;
  logic        is_clr;
  logic        go;
  logic [31:0] old_ext;
  logic        tbl_flag;
  logic        tbl_flag_next;

  assign is_wr   = (kind_q == KIND_WRITE);
  assign is_inv  = (kind_q == KIND_INVAL);
  assign is_clr  = inr_q && (kind_q == KIND_CLEAR);
  assign nv      = is_wr ? slot_q : SlotInv;
  assign go      = is_wr || (is_inv && (srdata == slot_q));
  assign chg     = inr_q && go && (srdata != nv);
  assign old_ext = 32'(srdata);

  always_comb begin
    tbl_flag_next = tbl_flag;
    if (chg) begin
      tbl_flag_next = 1'b1;
    end else if (is_clr) begin
      tbl_flag_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tbl_flag  <= 1'b1;
      row_valid <= '0;
      done      <= 1'b0;
    end else begin
      done <= cmd.exec;
      if (cmd.exec) begin
        tbl_flag <= tbl_flag_next;
        if (chg) begin
          row_valid[trow_idx] <= 1'b1;
        end else if (is_clr) begin
          row_valid <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      in_range    <= inr_q;
      slot_out    <= inr_q ? old_ext[SLOT_IO_W-1:0] : InvExt[SLOT_IO_W-1:0];
      changed     <= chg;
      tile_dirty  <= inr_q && !is_clr && (chg || row_word[tbit_idx]);
      table_dirty <= tbl_flag_next;
    end
  end

endmodule

// ===== bench/tb_mip_indirection_table.sv =====
// ----------------------------------------------------------------------------
// tb_mip_indirection_table
// Self-checking bench for the mip indirection table. A directed table covers
// reset contents, range edges, unchanged writes, conditional invalidates,
// dirty tracking and the spare kinds. Random transactions follow, with the
// sender idling at varied rates. Each result is compared field by field to its
// directed expectation or to a local table model tracking each transaction.
// ----------------------------------------------------------------------------
module tb_mip_indirection_table import mit_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int SIDE        = 256;
  localparam int TILE_SIDE   = 16;
  localparam int NUM_LEVELS  = $clog2(SIDE) + 1;
  localparam int TABLE_DEPTH = (SIDE * SIDE * 4 - 1) / 3;
  localparam int TILE_DEPTH  = 345;  // tile squares summed over the chain
  localparam int N_DIRECTED  = 25;
  localparam int N_PER_PHASE = 550;
  localparam int MAX_REPORTS = 25;

  localparam logic [SLOT_IO_W-1:0] SLOT_INVALID = '1;
  localparam logic [KIND_W-1:0] KIND_SPARE5 = 3'd5;
  localparam logic [KIND_W-1:0] KIND_SPARE6 = 3'd6;
  localparam logic [KIND_W-1:0] KIND_SPARE7 = 3'd7;

  typedef struct packed {
    logic [KIND_W-1:0]    kind;
    logic [POS_W-1:0]     column;
    logic [POS_W-1:0]     row;
    logic [LVL_W-1:0]     level;
    logic [SLOT_IO_W-1:0] slot;
  } table_item_t;

  typedef struct packed {
    logic                 in_range;
    logic [SLOT_IO_W-1:0] slot_out;
    logic                 changed;
    logic                 tile_dirty;
    logic                 table_dirty;
  } table_result_t;

  typedef struct packed {
    table_item_t   item;
    logic          typed;
    table_result_t want;
  } directed_row_t;

  typedef struct packed {
    logic [POS_W-1:0] column;
    logic [POS_W-1:0] row;
    logic [LVL_W-1:0] level;
  } page_addr_t;

  localparam table_result_t RES_FRESH   = '{1'b1, SLOT_INVALID, 1'b0, 1'b0, 1'b1};
  localparam table_result_t RES_OOR     = '{1'b0, SLOT_INVALID, 1'b0, 1'b0, 1'b1};
  localparam table_result_t RES_CLEARED = '{1'b1, SLOT_INVALID, 1'b0, 1'b0, 1'b0};
  localparam table_result_t RES_MODEL   = '0;

  localparam directed_row_t DIRECTED [N_DIRECTED] = '{
    '{'{KIND_READ,   9'd0,   9'd0,   4'd0,  SLOT_INVALID}, 1'b1, RES_FRESH},
    '{'{KIND_READ,   9'd255, 9'd255, 4'd0,  SLOT_INVALID}, 1'b1, RES_FRESH},
    '{'{KIND_READ,   9'd0,   9'd0,   4'd8,  SLOT_INVALID}, 1'b1, RES_FRESH},
    '{'{KIND_READ,   9'd256, 9'd0,   4'd0,  16'h0000},     1'b1, RES_OOR},
    '{'{KIND_READ,   9'd511, 9'd511, 4'd0,  16'h0000},     1'b1, RES_OOR},
    '{'{KIND_WRITE,  9'd0,   9'd0,   4'd9,  16'h0001},     1'b1, RES_OOR},
    '{'{KIND_CLEAR,  9'd0,   9'd0,   4'd15, 16'h0000},     1'b1, RES_OOR},
    '{'{KIND_WRITE,  9'd1,   9'd0,   4'd8,  16'h0001},     1'b1, RES_OOR},
    '{'{KIND_CLEAR,  9'd0,   9'd0,   4'd0,  16'h0000},     1'b1, RES_CLEARED},
    '{'{KIND_QUERY,  9'd0,   9'd0,   4'd0,  16'h0000},     1'b1, RES_CLEARED},
    '{'{KIND_WRITE,  9'd0,   9'd0,   4'd0,  16'h0000},     1'b0, RES_MODEL},
    '{'{KIND_WRITE,  9'd0,   9'd0,   4'd0,  16'h0000},     1'b0, RES_MODEL},
    '{'{KIND_CLEAR,  9'd5,   9'd5,   4'd3,  16'h0000},     1'b0, RES_MODEL},
    '{'{KIND_WRITE,  9'd0,   9'd0,   4'd0,  SLOT_INVALID}, 1'b0, RES_MODEL},
    '{'{KIND_WRITE,  9'd0,   9'd0,   4'd0,  SLOT_INVALID}, 1'b0, RES_MODEL},
    '{'{KIND_WRITE,  9'd255, 9'd255, 4'd0,  16'h1234},     1'b0, RES_MODEL},
    '{'{KIND_INVAL,  9'd255, 9'd255, 4'd0,  16'h1235},     1'b0, RES_MODEL},
    '{'{KIND_INVAL,  9'd255, 9'd255, 4'd0,  16'h1234},     1'b0, RES_MODEL},
    '{'{KIND_INVAL,  9'd255, 9'd255, 4'd0,  SLOT_INVALID}, 1'b0, RES_MODEL},
    '{'{KIND_SPARE5, 9'd255, 9'd255, 4'd0,  16'h0007},     1'b0, RES_MODEL},
    '{'{KIND_SPARE6, 9'd15,  9'd15,  4'd0,  16'h0007},     1'b0, RES_MODEL},
    '{'{KIND_SPARE7, 9'd16,  9'd0,   4'd0,  16'h0007},     1'b0, RES_MODEL},
    '{'{KIND_WRITE,  9'd0,   9'd0,   4'd8,  16'hAAAA},     1'b0, RES_MODEL},
    '{'{KIND_QUERY,  9'd0,   9'd0,   4'd8,  16'h0000},     1'b0, RES_MODEL},
    '{'{KIND_QUERY,  9'd16,  9'd16,  4'd0,  16'h0000},     1'b0, RES_MODEL}
  };

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 start = 1'b0;
  logic [KIND_W-1:0]    kind = KIND_READ;
  logic [POS_W-1:0]     column = '0;
  logic [POS_W-1:0]     row = '0;
  logic [LVL_W-1:0]     level = '0;
  logic [SLOT_IO_W-1:0] slot_in = '0;
  logic                 busy;
  logic                 done;
  logic                 in_range;
  logic [SLOT_IO_W-1:0] slot_out;
  logic                 changed;
  logic                 tile_dirty;
  logic                 table_dirty;

  // local copy of the table state
  logic [SLOT_IO_W-1:0] slot_mem [TABLE_DEPTH];
  bit                   tile_marks [TILE_DEPTH];
  bit                   table_flag;

  table_result_t pending_lookups [$];
  table_result_t head;
  page_addr_t    recent_pages [$];

  int errors;
  int n_sent;
  int n_checked;
  int n_oor;
  int n_changed;

  mip_indirection_table u_dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .kind        (kind),
    .column      (column),
    .row         (row),
    .level       (level),
    .slot_in     (slot_in),
    .busy        (busy),
    .done        (done),
    .in_range    (in_range),
    .slot_out    (slot_out),
    .changed     (changed),
    .tile_dirty  (tile_dirty),
    .table_dirty (table_dirty)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  task automatic report_mismatch(string field, logic [SLOT_IO_W-1:0] got,
                                 logic [SLOT_IO_W-1:0] want);
    errors++;
    if (errors <= MAX_REPORTS)
      $display("%0t: mismatch on %s: got %h, expected %h", $realtime, field, got, want);
  endtask

  function automatic void table_reset();
    for (int i = 0; i < TABLE_DEPTH; i++) slot_mem[i] = SLOT_INVALID;
    for (int i = 0; i < TILE_DEPTH; i++) tile_marks[i] = 1'b0;
    table_flag = 1'b1;
  endfunction

  function automatic bit page_in_range(logic [POS_W-1:0] c, logic [POS_W-1:0] r,
                                       logic [LVL_W-1:0] l);
    if (l >= NUM_LEVELS) return 1'b0;
    return (c < (SIDE >> l)) && (r < (SIDE >> l));
  endfunction

  function automatic int entry_index(logic [POS_W-1:0] c, logic [POS_W-1:0] r,
                                     logic [LVL_W-1:0] l);
    int side;
    int base;
    side = SIDE;
    base = 0;
    for (int m = 0; m < l; m++) begin
      base += side * side;
      side >>= 1;
    end
    return base + r * side + c;
  endfunction

  function automatic int tile_index(logic [POS_W-1:0] c, logic [POS_W-1:0] r,
                                    logic [LVL_W-1:0] l);
    int side;
    int across;
    int base;
    side = SIDE;
    base = 0;
    for (int m = 0; m < l; m++) begin
      across = (side + TILE_SIDE - 1) / TILE_SIDE;
      base += across * across;
      side >>= 1;
    end
    across = (side + TILE_SIDE - 1) / TILE_SIDE;
    return base + (r / TILE_SIDE) * across + c / TILE_SIDE;
  endfunction

  // applies one transaction to the local table and returns its result
  function automatic table_result_t table_apply(table_item_t it);
    table_result_t res;
    logic [SLOT_IO_W-1:0] old;
    logic [SLOT_IO_W-1:0] nv;
    int e;
    int t;
    res = '0;
    if (!page_in_range(it.column, it.row, it.level)) begin
      res.slot_out = SLOT_INVALID;
      res.table_dirty = table_flag;
      return res;
    end
    e = entry_index(it.column, it.row, it.level);
    t = tile_index(it.column, it.row, it.level);
    old = slot_mem[e];
    if (it.kind == KIND_WRITE || it.kind == KIND_INVAL) begin
      nv = (it.kind == KIND_WRITE) ? it.slot : SLOT_INVALID;
      if ((it.kind == KIND_WRITE || old == it.slot) && old != nv) begin
        slot_mem[e] = nv;
        tile_marks[t] = 1'b1;
        table_flag = 1'b1;
        res.changed = 1'b1;
      end
    end else if (it.kind == KIND_CLEAR) begin
      for (int i = 0; i < TILE_DEPTH; i++) tile_marks[i] = 1'b0;
      table_flag = 1'b0;
    end
    res.in_range = 1'b1;
    res.slot_out = old;
    res.tile_dirty = tile_marks[t];
    res.table_dirty = table_flag;
    return res;
  endfunction

  // random transaction, biased toward recently touched pages
  function automatic table_item_t pick_item();
    table_item_t it;
    page_addr_t pg;
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 15)      it.kind = KIND_READ;
    else if (sel < 45) it.kind = KIND_WRITE;
    else if (sel < 65) it.kind = KIND_INVAL;
    else if (sel < 80) it.kind = KIND_QUERY;
    else if (sel < 85) it.kind = KIND_CLEAR;
    else               it.kind = 3'($urandom_range(KIND_SPARE5, KIND_SPARE7));
    sel = $urandom_range(0, 9);
    if (sel < 2) begin
      pg.column = 9'($urandom_range(0, 511));
      pg.row    = 9'($urandom_range(0, 511));
      pg.level  = 4'($urandom_range(0, 15));
    end else if (sel < 6 && recent_pages.size() != 0) begin
      pg = recent_pages[$urandom_range(0, recent_pages.size() - 1)];
    end else begin
      pg.level  = 4'($urandom_range(0, NUM_LEVELS - 1));
      pg.column = 9'($urandom_range(0, (SIDE >> pg.level) - 1));
      pg.row    = 9'($urandom_range(0, (SIDE >> pg.level) - 1));
      recent_pages = {recent_pages, pg};
      if (recent_pages.size() > 16) void'(recent_pages.pop_front());
    end
    it.column = pg.column;
    it.row    = pg.row;
    it.level  = pg.level;
    sel = $urandom_range(0, 9);
    if (sel == 0)
      it.slot = SLOT_INVALID;
    else if (sel < 5 && page_in_range(pg.column, pg.row, pg.level))
      it.slot = slot_mem[entry_index(pg.column, pg.row, pg.level)];
    else
      it.slot = 16'($urandom());
    return it;
  endfunction

  task automatic send_item(table_item_t it, logic typed, table_result_t want);
    table_result_t res;
    start   <= 1'b1;
    kind    <= it.kind;
    column  <= it.column;
    row     <= it.row;
    level   <= it.level;
    slot_in <= it.slot;
    do @(posedge clk); while (busy);
    res = table_apply(it);
    pending_lookups = {pending_lookups, (typed ? want : res)};
    n_sent++;
    if (!res.in_range) n_oor++;
    if (res.changed) n_changed++;
  endtask

  task automatic sender_gap(int pct);
    if ($urandom_range(0, 99) < pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  endtask

  task automatic drain_pending();
    start <= 1'b0;
    do @(posedge clk); while (pending_lookups.size() != 0);
  endtask

  always @(posedge clk) begin
    if (!rst && done) begin
      if (pending_lookups.size() == 0) begin
        report_mismatch("unexpected transaction", slot_out, SLOT_INVALID);
      end else begin
        head = pending_lookups.pop_front();
        n_checked++;
        if (in_range !== head.in_range)
          report_mismatch("in_range", 16'(in_range), 16'(head.in_range));
        if (slot_out !== head.slot_out)
          report_mismatch("slot_out", slot_out, head.slot_out);
        if (changed !== head.changed)
          report_mismatch("changed", 16'(changed), 16'(head.changed));
        if (tile_dirty !== head.tile_dirty)
          report_mismatch("tile_dirty", 16'(tile_dirty), 16'(head.tile_dirty));
        if (table_dirty !== head.table_dirty)
          report_mismatch("table_dirty", 16'(table_dirty), 16'(head.table_dirty));
      end
    end
  end

  initial begin
    table_reset();
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < N_DIRECTED; i++)
      send_item(DIRECTED[i].item, DIRECTED[i].typed, DIRECTED[i].want);
    drain_pending();

    for (int i = 0; i < N_PER_PHASE; i++) begin
      send_item(pick_item(), 1'b0, RES_MODEL);
      if (i < N_PER_PHASE - 1) sender_gap(8);
    end
    drain_pending();
    for (int i = 0; i < N_PER_PHASE; i++) begin
      send_item(pick_item(), 1'b0, RES_MODEL);
      if (i < N_PER_PHASE - 1) sender_gap(68);
    end
    drain_pending();
    for (int i = 0; i < N_PER_PHASE; i++)
      send_item(pick_item(), 1'b0, RES_MODEL);

    drain_pending();
    repeat (10) @(posedge clk);

    $display("%0d transactions sent, %0d results checked, %0d mismatches",
             n_sent, n_checked, errors);
    $display("%0d out of range, %0d changed an entry", n_oor, n_changed);
    if (errors == 0 && pending_lookups.size() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    #2000000;
    $display("timeout with %0d results outstanding", pending_lookups.size());
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
